/* hw/rtl/pfa_pkg.sv */
package pfa_pkg;

  localparam int unsigned PAIR_ENTRIES = 256;
  localparam int unsigned IP_ENTRIES   = 256;
  localparam int unsigned LENGTH_BINS  = 2048;

  localparam int unsigned PAIR_AW = $clog2(PAIR_ENTRIES);
  localparam int unsigned IP_AW   = $clog2(IP_ENTRIES);
  localparam int unsigned PAIR_CW = $clog2(PAIR_ENTRIES + 1);
  localparam int unsigned IP_CW   = $clog2(IP_ENTRIES + 1);
  localparam int unsigned SCAN_CW = (PAIR_CW > IP_CW) ? PAIR_CW : IP_CW;
  localparam int unsigned HIST_AW = $clog2(LENGTH_BINS);

  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [31:0] FIRST_TIME_RESET = 32'd2147483647;

  localparam logic [10:0] STAT_TOTAL    = 11'd0;
  localparam logic [10:0] STAT_UDP      = 11'd1;
  localparam logic [10:0] STAT_TCP      = 11'd2;
  localparam logic [10:0] STAT_ICMP     = 11'd3;
  localparam logic [10:0] STAT_OTHER    = 11'd4;
  localparam logic [10:0] STAT_SYN      = 11'd5;
  localparam logic [10:0] STAT_SYNACK   = 11'd6;
  localparam logic [10:0] STAT_ACK      = 11'd7;
  localparam logic [10:0] STAT_RST      = 11'd8;
  localparam logic [10:0] STAT_FIN      = 11'd9;
  localparam logic [10:0] STAT_BYTES    = 11'd10;
  localparam logic [10:0] STAT_FIRST    = 11'd11;
  localparam logic [10:0] STAT_LATEST   = 11'd12;
  localparam logic [10:0] STAT_RECENT   = 11'd13;
  localparam logic [10:0] STAT_UDP_USED = 11'd14;
  localparam logic [10:0] STAT_TCP_USED = 11'd15;
  localparam logic [10:0] STAT_IP_USED  = 11'd16;

  typedef enum logic [1:0] {
    ACT_PACKET    = 2'd0,
    ACT_READ_STAT = 2'd1,
    ACT_READ_BIN  = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TBL_UDP = 2'd0,
    TBL_TCP = 2'd1,
    TBL_IP  = 2'd2
  } tbl_sel_e;

  typedef struct packed {
    logic        start;
    tbl_sel_e    sel;
    logic [47:0] key;
  } tbl_req_t;

  typedef struct packed {
    logic        done;
    logic        full;
    logic [31:0] count;
  } tbl_rsp_t;

  typedef struct packed {
    logic [PAIR_CW-1:0] udp;
    logic [PAIR_CW-1:0] tcp;
    logic [IP_CW-1:0]   ip;
  } tbl_used_t;

endpackage

/* hw/rtl/pfa_table.sv */
module pfa_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfa_pkg::tbl_req_t  req_i,
  output pfa_pkg::tbl_rsp_t  rsp_o,
  output pfa_pkg::tbl_used_t used_o
);
  import pfa_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_SCAN = 2'b10
  } tstate_e;

  tstate_e state_q, state_d;
  tbl_sel_e sel_q, sel_d;
  logic [47:0] key_q, key_d;
  logic [SCAN_CW-1:0] idx_q, idx_d, rd_idx;
  logic [PAIR_CW-1:0] udp_used_q, udp_used_d, tcp_used_q, tcp_used_d;
  logic [IP_CW-1:0] ip_used_q, ip_used_d;
  tbl_rsp_t rsp_q, rsp_d;

  logic [79:0] udp_mem [PAIR_ENTRIES];
  logic [79:0] tcp_mem [PAIR_ENTRIES];
  logic [63:0] ip_mem [IP_ENTRIES];
  logic [79:0] rd_udp_q, rd_tcp_q;
  logic [63:0] rd_ip_q;

  logic wr_en;
  tbl_sel_e wr_sel;
  logic [SCAN_CW-1:0] wr_addr;
  logic [47:0] wr_key;
  logic [31:0] wr_cnt;

  logic [SCAN_CW-1:0] used_cur, used_req, depth_cur, idx_next;
  logic hit;
  logic [31:0] rd_cnt;

  always_comb begin
    case (sel_q)
      TBL_UDP: begin
        used_cur  = SCAN_CW'(udp_used_q);
        depth_cur = SCAN_CW'(PAIR_ENTRIES);
        hit       = rd_udp_q[79:32] == key_q;
        rd_cnt    = rd_udp_q[31:0];
      end
      TBL_TCP: begin
        used_cur  = SCAN_CW'(tcp_used_q);
        depth_cur = SCAN_CW'(PAIR_ENTRIES);
        hit       = rd_tcp_q[79:32] == key_q;
        rd_cnt    = rd_tcp_q[31:0];
      end
      default: begin
        used_cur  = SCAN_CW'(ip_used_q);
        depth_cur = SCAN_CW'(IP_ENTRIES);
        hit       = rd_ip_q[63:32] == key_q[47:16];
        rd_cnt    = rd_ip_q[31:0];
      end
    endcase
    case (req_i.sel)
      TBL_UDP: used_req = SCAN_CW'(udp_used_q);
      TBL_TCP: used_req = SCAN_CW'(tcp_used_q);
      default: used_req = SCAN_CW'(ip_used_q);
    endcase
  end

  assign idx_next = idx_q + SCAN_CW'(1);

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    key_d      = key_q;
    idx_d      = idx_q;
    rd_idx     = idx_q;
    udp_used_d = udp_used_q;
    tcp_used_d = tcp_used_q;
    ip_used_d  = ip_used_q;
    rsp_d      = '0;
    wr_en      = 1'b0;
    wr_sel     = sel_q;
    wr_addr    = idx_q;
    wr_key     = key_q;
    wr_cnt     = 32'd1;
    case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          sel_d  = req_i.sel;
          key_d  = req_i.key;
          idx_d  = '0;
          rd_idx = '0;
          if (used_req == '0) begin
            wr_en       = 1'b1;
            wr_sel      = req_i.sel;
            wr_addr     = '0;
            wr_key      = req_i.key;
            rsp_d.done  = 1'b1;
            rsp_d.count = 32'd1;
            case (req_i.sel)
              TBL_UDP: udp_used_d = PAIR_CW'(1);
              TBL_TCP: tcp_used_d = PAIR_CW'(1);
              default: ip_used_d  = IP_CW'(1);
            endcase
          end else begin
            state_d = T_SCAN;
          end
        end
      end
      T_SCAN: begin
        if (hit) begin
          wr_en       = 1'b1;
          wr_cnt      = rd_cnt + 32'd1;
          rsp_d.done  = 1'b1;
          rsp_d.count = rd_cnt + 32'd1;
          state_d     = T_IDLE;
        end else if (idx_next < used_cur) begin
          idx_d  = idx_next;
          rd_idx = idx_next;
        end else if (used_cur == depth_cur) begin
          rsp_d.done = 1'b1;
          rsp_d.full = 1'b1;
          state_d    = T_IDLE;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = used_cur;
          rsp_d.done  = 1'b1;
          rsp_d.count = 32'd1;
          state_d     = T_IDLE;
          case (sel_q)
            TBL_UDP: udp_used_d = udp_used_q + PAIR_CW'(1);
            TBL_TCP: tcp_used_d = tcp_used_q + PAIR_CW'(1);
            default: ip_used_d  = ip_used_q + IP_CW'(1);
          endcase
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_sel == TBL_UDP) begin
      udp_mem[wr_addr[PAIR_AW-1:0]] <= {wr_key, wr_cnt};
    end
    if (wr_en && wr_sel == TBL_TCP) begin
      tcp_mem[wr_addr[PAIR_AW-1:0]] <= {wr_key, wr_cnt};
    end
    if (wr_en && wr_sel == TBL_IP) begin
      ip_mem[wr_addr[IP_AW-1:0]] <= {wr_key[47:16], wr_cnt};
    end
    rd_udp_q <= udp_mem[rd_idx[PAIR_AW-1:0]];
    rd_tcp_q <= tcp_mem[rd_idx[PAIR_AW-1:0]];
    rd_ip_q  <= ip_mem[rd_idx[IP_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    key_q <= key_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      udp_used_q <= '0;
      tcp_used_q <= '0;
      ip_used_q  <= '0;
      rsp_q      <= '0;
    end else begin
      state_q    <= state_d;
      udp_used_q <= udp_used_d;
      tcp_used_q <= tcp_used_d;
      ip_used_q  <= ip_used_d;
      rsp_q      <= rsp_d;
    end
  end

  assign rsp_o      = rsp_q;
  assign used_o.udp = udp_used_q;
  assign used_o.tcp = tcp_used_q;
  assign used_o.ip  = ip_used_q;

endmodule

/* hw/rtl/packet_feature_accumulator.sv */
// Packet statistics engine. Each beat on the input carries one action in tuser: a packet
// record, a statistic read, a histogram bin read or no action, and each yields exactly one
// output beat. Items are processed one at a time. The contact tables are searched linearly,
// one memory entry per cycle, up to the number of entries in use. After reset the length
// histogram memory is cleared one bin per cycle, so no input is accepted until all 2048
// bins are cleared.
module packet_feature_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_ip, protocol, dest_port, flag_syn, flag_ack, flag_rst, flag_fin,
  // packet_length, timestamp, read_index, zero pad.
  input  logic [119:0] s_axis_tdata,
  // action.
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accepted, entry_count, table_full, read_value, zero pad.
  output logic [103:0] m_axis_tdata
);
  import pfa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HIST  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  action_e     in_act;
  logic [31:0] in_ip, in_ts;
  logic [7:0]  in_proto;
  logic [15:0] in_port, in_len;
  logic        in_syn, in_ack, in_rst, in_fin;
  logic [10:0] in_ridx;

  assign in_act   = action_e'(s_axis_tuser);
  assign in_ip    = s_axis_tdata[31:0];
  assign in_proto = s_axis_tdata[39:32];
  assign in_port  = s_axis_tdata[55:40];
  assign in_syn   = s_axis_tdata[56];
  assign in_ack   = s_axis_tdata[57];
  assign in_rst   = s_axis_tdata[58];
  assign in_fin   = s_axis_tdata[59];
  assign in_len   = s_axis_tdata[75:60];
  assign in_ts    = s_axis_tdata[107:76];
  assign in_ridx  = s_axis_tdata[118:108];

  logic accept;
  assign s_axis_tready = state_q == S_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [31:0] total_q, first_q, latest_q, recent_q;
  logic [31:0] proto_q [4];
  logic [31:0] flag_q [5];
  logic [63:0] bytes_q;

  logic        is_pkt_q, bin_ok_q, tbl_busy_q;
  logic [HIST_AW-1:0] bin_q, clr_q;
  logic        acc_q, acc_d, full_q, full_d;
  logic [31:0] cnt_q, cnt_d;
  logic [63:0] rv_q, rv_d, stat_val;
  logic        m_valid_q;
  logic [103:0] m_data_q;

  tbl_req_t  tbl_req;
  tbl_rsp_t  tbl_rsp;
  tbl_used_t tbl_used;

  pfa_table u_table (
    .clk_i,
    .rst_ni,
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp),
    .used_o (tbl_used)
  );

  logic pkt_ok, tcp_scan;
  logic [HIST_AW-1:0] in_bin;
  assign pkt_ok   = accept && in_act == ACT_PACKET && in_ip != 32'd0;
  assign tcp_scan = (in_syn && !in_ack) || (!in_syn && !in_ack && !in_rst);
  assign in_bin   = (32'(in_len) < LENGTH_BINS) ? HIST_AW'(in_len) : HIST_AW'(LENGTH_BINS - 1);

  always_comb begin
    tbl_req.start = 1'b0;
    tbl_req.sel   = TBL_IP;
    tbl_req.key   = {in_ip, 16'd0};
    if (in_proto == PROTO_UDP) begin
      tbl_req.start = pkt_ok;
      tbl_req.sel   = TBL_UDP;
      tbl_req.key   = {in_ip, in_port};
    end else if (in_proto == PROTO_TCP) begin
      tbl_req.start = pkt_ok && tcp_scan;
      tbl_req.sel   = TBL_TCP;
      tbl_req.key   = {in_ip, in_port};
    end else begin
      tbl_req.start = pkt_ok;
    end
  end

  always_comb begin
    case (in_ridx)
      STAT_TOTAL:    stat_val = 64'(total_q);
      STAT_UDP:      stat_val = 64'(proto_q[0]);
      STAT_TCP:      stat_val = 64'(proto_q[1]);
      STAT_ICMP:     stat_val = 64'(proto_q[2]);
      STAT_OTHER:    stat_val = 64'(proto_q[3]);
      STAT_SYN:      stat_val = 64'(flag_q[0]);
      STAT_SYNACK:   stat_val = 64'(flag_q[1]);
      STAT_ACK:      stat_val = 64'(flag_q[2]);
      STAT_RST:      stat_val = 64'(flag_q[3]);
      STAT_FIN:      stat_val = 64'(flag_q[4]);
      STAT_BYTES:    stat_val = bytes_q;
      STAT_FIRST:    stat_val = 64'(first_q);
      STAT_LATEST:   stat_val = 64'(latest_q);
      STAT_RECENT:   stat_val = 64'(recent_q);
      STAT_UDP_USED: stat_val = 64'(tbl_used.udp);
      STAT_TCP_USED: stat_val = 64'(tbl_used.tcp);
      STAT_IP_USED:  stat_val = 64'(tbl_used.ip);
      default:       stat_val = 64'd0;
    endcase
  end

  logic [31:0] hist_mem [LENGTH_BINS];
  logic [31:0] h_rd_q, h_wd;
  logic [HIST_AW-1:0] h_ra, h_wa;
  logic h_we;

  assign h_ra = (in_act == ACT_READ_BIN) ? HIST_AW'(in_ridx) : in_bin;

  always_comb begin
    h_we = 1'b0;
    h_wa = bin_q;
    h_wd = h_rd_q + 32'd1;
    if (state_q == S_CLEAR) begin
      h_we = 1'b1;
      h_wa = clr_q;
      h_wd = 32'd0;
    end else if (state_q == S_HIST && is_pkt_q) begin
      h_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    h_rd_q <= hist_mem[h_ra];
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    full_d  = full_q;
    rv_d    = rv_q;
    if (tbl_rsp.done) begin
      cnt_d  = tbl_rsp.count;
      full_d = tbl_rsp.full;
    end
    case (state_q)
      S_CLEAR: begin
        if (clr_q == HIST_AW'(LENGTH_BINS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          acc_d   = pkt_ok;
          cnt_d   = 32'd0;
          full_d  = 1'b0;
          rv_d    = 64'd0;
          state_d = S_RESP;
          if (in_act == ACT_READ_STAT) begin
            rv_d = stat_val;
          end else if (in_act == ACT_READ_BIN || pkt_ok) begin
            state_d = S_HIST;
          end
        end
      end
      S_HIST: begin
        if (!is_pkt_q) begin
          rv_d = bin_ok_q ? 64'(h_rd_q) : 64'd0;
        end
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!tbl_busy_q) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    full_q <= full_d;
    rv_q   <= rv_d;
    if (accept) begin
      is_pkt_q <= pkt_ok;
      bin_q    <= in_bin;
      bin_ok_q <= 32'(in_ridx) < LENGTH_BINS;
    end
    if (state_q == S_RESP && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {6'd0, rv_q, full_q, cnt_q, acc_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      tbl_busy_q <= 1'b0;
      m_valid_q  <= 1'b0;
      total_q    <= '0;
      proto_q    <= '{default: '0};
      flag_q     <= '{default: '0};
      bytes_q    <= '0;
      first_q    <= FIRST_TIME_RESET;
      latest_q   <= '0;
      recent_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + HIST_AW'(1);
      end
      if (tbl_req.start) begin
        tbl_busy_q <= 1'b1;
      end else if (tbl_rsp.done) begin
        tbl_busy_q <= 1'b0;
      end
      if (state_q == S_RESP && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (pkt_ok) begin
        total_q  <= total_q + 32'd1;
        bytes_q  <= bytes_q + 64'(in_len);
        recent_q <= in_ts;
        if (in_ts < first_q) begin
          first_q <= in_ts;
        end
        if (in_ts > latest_q) begin
          latest_q <= in_ts;
        end
        if (in_proto == PROTO_UDP) begin
          proto_q[0] <= proto_q[0] + 32'd1;
        end else if (in_proto == PROTO_TCP) begin
          proto_q[1] <= proto_q[1] + 32'd1;
          if (in_syn && in_ack) begin
            flag_q[1] <= flag_q[1] + 32'd1;
          end else if (in_syn) begin
            flag_q[0] <= flag_q[0] + 32'd1;
          end else if (in_ack) begin
            flag_q[2] <= flag_q[2] + 32'd1;
          end
          if (in_rst) begin
            flag_q[3] <= flag_q[3] + 32'd1;
          end
          if (in_fin) begin
            flag_q[4] <= flag_q[4] + 32'd1;
          end
        end else if (in_proto == PROTO_ICMP) begin
          proto_q[2] <= proto_q[2] + 32'd1;
        end else begin
          proto_q[3] <= proto_q[3] + 32'd1;
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_done_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_rsp.done |-> tbl_busy_q)
    else $error("table response without a pending lookup");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tbl_used.udp) <= PAIR_ENTRIES && 32'(tbl_used.tcp) <= PAIR_ENTRIES &&
    32'(tbl_used.ip) <= IP_ENTRIES)
    else $error("table fill count beyond depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("second beat taken while an item is in progress");

  a_full_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && full_q) |-> cnt_q == 32'd0)
    else $error("full table reported with a nonzero count");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pfa_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic [31:0] entry_count;
    logic        table_full;
    logic [63:0] read_value;
  } result_t;

  typedef struct packed {
    action_e     act;
    logic [31:0] ip;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [3:0]  flags;  // {fin, rst, ack, syn}
    logic [15:0] len;
    logic [31:0] ts;
    logic [10:0] idx;
  } record_t;

  typedef struct packed {
    record_t rec;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 6000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  packet_feature_accumulator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  bit [31:0] pkt_total;
  bit [31:0] proto_cnt [4];
  bit [31:0] flag_cnt [5];
  bit [63:0] byte_total;
  bit [31:0] t_first = FIRST_TIME_RESET;
  bit [31:0] t_max;
  bit [31:0] t_recent;
  bit [31:0] pair_ip [2][PAIR_ENTRIES];
  bit [15:0] pair_port [2][PAIR_ENTRIES];
  bit [31:0] pair_cnt [2][PAIR_ENTRIES];
  int unsigned pair_used [2];
  bit [31:0] host_ip [IP_ENTRIES];
  bit [31:0] host_cnt [IP_ENTRIES];
  int unsigned host_used;
  bit [31:0] len_hist [LENGTH_BINS];

  result_t   expected_q [$];
  int        errors;
  bit        idle_on;
  int        quiet_cycles;
  int        stall_left;
  bit [31:0] key_ip [$];
  bit [15:0] key_port [$];

  function automatic bit [31:0] bump_pair(int t, bit [31:0] ip, bit [15:0] port,
                                          ref logic full);
    for (int i = 0; i < pair_used[t]; i++) begin
      if (pair_ip[t][i] == ip && pair_port[t][i] == port) begin
        pair_cnt[t][i] += 1;
        return pair_cnt[t][i];
      end
    end
    if (pair_used[t] >= PAIR_ENTRIES) begin
      full = 1'b1;
      return 0;
    end
    pair_ip[t][pair_used[t]] = ip;
    pair_port[t][pair_used[t]] = port;
    pair_cnt[t][pair_used[t]] = 1;
    pair_used[t]++;
    return 1;
  endfunction

  function automatic bit [31:0] bump_host(bit [31:0] ip, ref logic full);
    for (int i = 0; i < host_used; i++) begin
      if (host_ip[i] == ip) begin
        host_cnt[i] += 1;
        return host_cnt[i];
      end
    end
    if (host_used >= IP_ENTRIES) begin
      full = 1'b1;
      return 0;
    end
    host_ip[host_used] = ip;
    host_cnt[host_used] = 1;
    host_used++;
    return 1;
  endfunction

  function automatic bit [63:0] stat_value(logic [10:0] idx);
    case (idx)
      STAT_TOTAL:    return 64'(pkt_total);
      STAT_UDP:      return 64'(proto_cnt[0]);
      STAT_TCP:      return 64'(proto_cnt[1]);
      STAT_ICMP:     return 64'(proto_cnt[2]);
      STAT_OTHER:    return 64'(proto_cnt[3]);
      STAT_SYN:      return 64'(flag_cnt[0]);
      STAT_SYNACK:   return 64'(flag_cnt[1]);
      STAT_ACK:      return 64'(flag_cnt[2]);
      STAT_RST:      return 64'(flag_cnt[3]);
      STAT_FIN:      return 64'(flag_cnt[4]);
      STAT_BYTES:    return byte_total;
      STAT_FIRST:    return 64'(t_first);
      STAT_LATEST:   return 64'(t_max);
      STAT_RECENT:   return 64'(t_recent);
      STAT_UDP_USED: return 64'(pair_used[0]);
      STAT_TCP_USED: return 64'(pair_used[1]);
      STAT_IP_USED:  return 64'(host_used);
      default:       return 64'd0;
    endcase
  endfunction

  function automatic result_t account(record_t r);
    result_t res;
    logic    syn, ack, rst, fin;
    logic    full;
    res = '0;
    full = 1'b0;
    {fin, rst, ack, syn} = r.flags;
    case (r.act)
      ACT_READ_STAT: res.read_value = stat_value(r.idx);
      ACT_READ_BIN:  res.read_value = (r.idx < LENGTH_BINS) ? 64'(len_hist[r.idx]) : 64'd0;
      ACT_PACKET: begin
        if (r.ip != 0) begin
          res.accepted = 1'b1;
          if (r.proto == PROTO_UDP) begin
            proto_cnt[0] += 1;
            res.entry_count = bump_pair(0, r.ip, r.port, full);
          end else if (r.proto == PROTO_TCP) begin
            proto_cnt[1] += 1;
            if ((syn && !ack) || (!syn && !ack && !rst))
              res.entry_count = bump_pair(1, r.ip, r.port, full);
            if (syn && ack) flag_cnt[1] += 1;
            else if (syn) flag_cnt[0] += 1;
            else if (ack) flag_cnt[2] += 1;
            if (rst) flag_cnt[3] += 1;
            if (fin) flag_cnt[4] += 1;
          end else if (r.proto == PROTO_ICMP) begin
            proto_cnt[2] += 1;
            res.entry_count = bump_host(r.ip, full);
          end else begin
            proto_cnt[3] += 1;
            res.entry_count = bump_host(r.ip, full);
          end
          pkt_total += 1;
          byte_total += 64'(r.len);
          len_hist[(r.len < LENGTH_BINS) ? r.len : LENGTH_BINS - 1] += 1;
          t_recent = r.ts;
          if (r.ts < t_first) t_first = r.ts;
          if (r.ts > t_max) t_max = r.ts;
        end
      end
      default: ;
    endcase
    res.table_full = full;
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t got, want;
    if (s_axis_tvalid && s_axis_tready) quiet_cycles <= 0;
    else if (m_axis_tvalid && m_axis_tready) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL packet_feature_accumulator");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.accepted    = m_axis_tdata[0];
      got.entry_count = m_axis_tdata[32:1];
      got.table_full  = m_axis_tdata[33];
      got.read_value  = m_axis_tdata[97:34];
      if (expected_q.size() == 0) begin
        report("unexpected beat", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.accepted !== want.accepted)
          report("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.entry_count !== want.entry_count)
          report("entry_count", 64'(got.entry_count), 64'(want.entry_count));
        if (got.table_full !== want.table_full)
          report("table_full", 64'(got.table_full), 64'(want.table_full));
        if (got.read_value !== want.read_value)
          report("read_value", got.read_value, want.read_value);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send(record_t r, logic typed, result_t res);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, r.idx, r.ts, r.len, r.flags, r.port, r.proto, r.ip};
    s_axis_tuser  <= r.act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (typed) begin
      void'(account(r));
      expected_q.push_back(res);
    end else begin
      expected_q.push_back(account(r));
    end
    @(negedge clk_i);
  endtask

  function automatic record_t random_packet(int fresh_pct, int proto_sel);
    record_t r;
    int      k;
    r = '0;
    r.act = ACT_PACKET;
    if (key_ip.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
      r.ip = $urandom();
      r.port = 16'($urandom());
      if ($urandom_range(0, 3) == 0) r.port = 16'($urandom_range(0, 3));
      key_ip.push_back(r.ip);
      key_port.push_back(r.port);
    end else begin
      k = $urandom_range(0, key_ip.size() - 1);
      r.ip = key_ip[k];
      r.port = key_port[k];
    end
    if (proto_sel < 0 && $urandom_range(0, 40) == 0) r.ip = 0;
    case ((proto_sel < 0) ? $urandom_range(0, 3) : proto_sel)
      0: r.proto = PROTO_UDP;
      1: r.proto = PROTO_TCP;
      2: r.proto = PROTO_ICMP;
      default: begin
        do r.proto = 8'($urandom()); while (r.proto inside {PROTO_UDP, PROTO_TCP, PROTO_ICMP});
      end
    endcase
    r.flags = 4'($urandom());
    if (proto_sel == 1) r.flags[1:0] = 2'b01;
    r.len = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2100));
    r.ts = $urandom();
    r.idx = 11'($urandom());
    return r;
  endfunction

  function automatic record_t random_item();
    record_t r;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return random_packet(30, -1);
    r = '0;
    r.ip = $urandom();
    r.idx = 11'($urandom());
    if (pick < 85) begin
      r.act = ACT_READ_STAT;
      if ($urandom_range(0, 4) != 0) r.idx = 11'($urandom_range(0, 18));
    end else if (pick < 97) begin
      r.act = ACT_READ_BIN;
      if ($urandom_range(0, 2) != 0) r.idx = 11'($urandom_range(0, 100));
    end else begin
      r.act = ACT_NONE;
    end
    return r;
  endfunction

  function automatic dir_row_t row(action_e act, logic [31:0] ip, logic [7:0] proto,
                                   logic [15:0] port, logic [3:0] flags, logic [15:0] len,
                                   logic [31:0] ts, logic [10:0] idx, logic typed,
                                   result_t res);
    dir_row_t d;
    d.rec = '{act, ip, proto, port, flags, len, ts, idx};
    d.typed = typed;
    d.res = res;
    return d;
  endfunction

  dir_row_t directed [$];

  initial begin
    result_t none;
    record_t rd;
    none = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_NONE;
    m_axis_tready = 1'b0;
    idle_on = 1'b1;

    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_TOTAL, 1, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_FIRST, 1,
                           '{0, 0, 0, 64'(FIRST_TIME_RESET)}));
    directed.push_back(row(ACT_READ_BIN, 0, 0, 0, 0, 0, 0, 0, 1, none));
    directed.push_back(row(ACT_READ_BIN, 0, 0, 0, 0, 0, 0, 11'h7ff, 1, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_IP_USED + 11'd1, 1, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, 11'h7ff, 1, none));
    directed.push_back(row(ACT_NONE, '1, '1, '1, '1, '1, '1, '1, 1, none));
    directed.push_back(row(ACT_PACKET, 0, PROTO_UDP, 80, 0, 100, 5, 0, 1, none));
    directed.push_back(row(ACT_PACKET, '1, PROTO_UDP, '1, 0, '1, '1, 0, 1, '{1, 1, 0, 0}));
    directed.push_back(row(ACT_PACKET, '1, PROTO_UDP, '1, 0, 0, 0, 0, 1, '{1, 2, 0, 0}));
    directed.push_back(row(ACT_PACKET, 32'h0a000001, PROTO_TCP, 22, 4'b0001, 60, 7, 0, 1,
                           '{1, 1, 0, 0}));
    directed.push_back(row(ACT_PACKET, 32'h0a000001, PROTO_TCP, 22, 4'b0011, 60, 8, 0, 1,
                           '{1, 0, 0, 0}));
    directed.push_back(row(ACT_PACKET, 32'h0a000001, PROTO_TCP, 22, 4'b0010, 60, 9, 0, 1,
                           '{1, 0, 0, 0}));
    directed.push_back(row(ACT_PACKET, 32'h0a000001, PROTO_TCP, 22, 4'b0100, 40, 9, 0, 1,
                           '{1, 0, 0, 0}));
    directed.push_back(row(ACT_PACKET, 32'h0a000001, PROTO_TCP, 23, 4'b1000, 40, 9, 0, 1,
                           '{1, 1, 0, 0}));
    directed.push_back(row(ACT_PACKET, 1, PROTO_ICMP, 0, 0, 2047, 3, 0, 1, '{1, 1, 0, 0}));
    directed.push_back(row(ACT_PACKET, 1, 8'hff, 0, 0, 2048, 3, 0, 1, '{1, 2, 0, 0}));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_BYTES, 0, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_FIRST, 0, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_LATEST, 0, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_RECENT, 0, none));
    directed.push_back(row(ACT_READ_STAT, 0, 0, 0, 0, 0, 0, STAT_RST, 0, none));
    directed.push_back(row(ACT_READ_BIN, 0, 0, 0, 0, 0, 0, 11'h7ff, 0, none));
    directed.push_back(row(ACT_READ_BIN, 0, 0, 0, 0, 0, 0, 0, 0, none));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send(directed[i].rec, directed[i].typed, directed[i].res);

    repeat (600) send(random_item(), 0, none);

    // Mostly new keys for every contact table, to drive them towards full, with reads and repeats mixed in.
    repeat (880) begin
      if ($urandom_range(0, 9) < 2) send(random_item(), 0, none);
      else send(random_packet(90, $urandom_range(0, 3)), 0, none);
    end
    for (int s = 0; s <= STAT_IP_USED; s++) begin
      rd = '0;
      rd.act = ACT_READ_STAT;
      rd.idx = 11'(s);
      send(rd, 0, none);
    end

    idle_on = 1'b0;
    repeat (300) send(random_item(), 0, none);
    s_axis_tvalid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS packet_feature_accumulator");
    end else begin
      $display("FAIL packet_feature_accumulator");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_table.sv
hw/rtl/packet_feature_accumulator.sv
tb/sv/tb_top.sv
